/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the step generator.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tspg_pkg.sv */
// Shared types and constants of the trapezoid step pulse generator.
// No dependencies.
package tspg_pkg;

    localparam int DEF_MOTOR_COUNT = 6;
    localparam int DEF_FRAC_BITS   = 30;

    localparam int CMD_W   = 3;
    localparam int IDX_W   = 3;
    localparam int TICK_W  = 24;
    localparam int RATE_W  = 32;
    localparam int MASK_W  = 6;
    localparam int MISS_W  = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD       = 3'd0,
        CMD_ACCEL_END  = 3'd1,
        CMD_DECEL_BEG  = 3'd2,
        CMD_START      = 3'd3,
        CMD_TICK       = 3'd4,
        CMD_HALT       = 3'd5,
        CMD_UNSTEP     = 3'd6
    } t_cmd;

    // Motor profile loaded by a load beat.
    typedef struct packed {
        logic [TICK_W-1:0] steps;
        logic [RATE_W-1:0] init_rate;
        logic [RATE_W-1:0] accel;
        logic [RATE_W-1:0] decel;
        logic [RATE_W-1:0] plateau;
        logic [TICK_W-1:0] first_event;
    } t_lane_load;

    // Block-wide timing seen by every motor lane.
    typedef struct packed {
        logic              tick;
        logic [TICK_W-1:0] tick_count;
        logic [TICK_W-1:0] accel_end;
        logic [TICK_W-1:0] decel_start;
        logic [TICK_W-1:0] block_length;
    } t_lane_ctrl;

    // Lane status back to the top level.
    typedef struct packed {
        logic active;
        logic step;
        logic finish;
    } t_lane_stat;

endpackage

/* hw/rtl/tspg_motor.sv */
// One motor lane: rate profile, phase accumulator and step count.
// Depends on tspg_pkg and assert_macros.svh.
module tspg_motor #(
    parameter int FRAC_BITS = tspg_pkg::DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load_en,
    input  tspg_pkg::t_lane_load  i_load,
    input  tspg_pkg::t_lane_ctrl  i_ctrl,
    input  logic                  i_moving,
    input  logic                  i_clear,
    output tspg_pkg::t_lane_stat  o_stat
);
    import tspg_pkg::*;
    `include "assert_macros.svh"

    localparam logic [RATE_W-1:0] ONE_STEP = RATE_W'(1) << FRAC_BITS;

    logic [TICK_W-1:0] r_target, r_steps_done, r_next_event;
    logic [RATE_W-1:0] r_rate, r_rate_change, r_decel_change, r_plateau, r_accum;

    logic [TICK_W-1:0] n_next_event, n_steps_done;
    logic [RATE_W-1:0] n_rate_change, rate_sum, rate_sel, rate_use, accum_base, accum_sum;
    logic [RATE_W-1:0] n_accum;
    logic              non_pos, overflow, active, step, finish;

    always_comb begin
        rate_sum      = r_rate + r_rate_change;
        rate_sel      = rate_sum;
        n_rate_change = r_rate_change;
        n_next_event  = r_next_event;
        if (i_ctrl.tick_count == r_next_event) begin
            if (i_ctrl.tick_count == i_ctrl.accel_end) begin
                n_rate_change = '0;
                if (i_ctrl.decel_start < i_ctrl.block_length) begin
                    n_next_event = i_ctrl.decel_start;
                    if (i_ctrl.tick_count != i_ctrl.decel_start) begin
                        rate_sel = r_plateau;
                    end
                end
            end
            if (i_ctrl.tick_count == i_ctrl.decel_start) begin
                n_rate_change = r_decel_change;
            end
        end
        // zero or wrapped-negative rate forces a step
        non_pos    = (rate_sel == '0) || rate_sel[RATE_W-1];
        accum_base = non_pos ? ONE_STEP : r_accum;
        rate_use   = non_pos ? '0 : rate_sel;
        accum_sum  = accum_base + rate_use;
        overflow   = (accum_sum >= ONE_STEP);
        n_accum    = overflow ? (accum_sum - ONE_STEP) : accum_sum;
        n_steps_done = r_steps_done + TICK_W'(1);
        active     = (r_target != '0);
        step       = i_ctrl.tick && active && overflow;
        finish     = step && (!i_moving || (n_steps_done == r_target));
    end

    assign o_stat.active = active;
    assign o_stat.step   = step;
    assign o_stat.finish = finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_clear) begin
            r_target <= '0;
        end else if (i_load_en) begin
            r_target <= i_load.steps;
        end else if (finish) begin
            r_target <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_rate         <= i_load.init_rate;
            r_rate_change  <= i_load.accel;
            r_decel_change <= i_load.decel;
            r_plateau      <= i_load.plateau;
            r_next_event   <= i_load.first_event;
            r_steps_done   <= '0;
            r_accum        <= '0;
        end else if (i_ctrl.tick && active) begin
            r_rate        <= rate_use;
            r_rate_change <= n_rate_change;
            r_next_event  <= n_next_event;
            r_accum       <= n_accum;
            if (overflow) begin
                r_steps_done <= n_steps_done;
            end
        end
    end

    `AST_IMPLY(a_finish_needs_step, i_clk, i_rst_n, finish, step, "finish without step")
    `AST_NEXT(a_finish_clears, i_clk, i_rst_n, finish && !i_load_en, r_target == '0,
        "finished lane kept its target")
    `AST_NEXT(a_load_zeroes_count, i_clk, i_rst_n, i_load_en,
        r_steps_done == '0 && r_accum == '0, "load left a stale count")

endmodule

/* hw/rtl/trapezoid_step_pulse_generator.sv */
// Top level of the trapezoid step pulse generator: beat registers, block control.
// Depends on tspg_pkg, tspg_motor and assert_macros.svh.
//
//  channel | handshake        | payload
//  --------+------------------+--------------------------------------------
//  in      | i_valid/o_ready  | command, motor fields, block_time, stop_mask
//  out     | o_valid/i_ready  | pin, direction, moving masks, status, count
//
// One beat per cycle sustained while the result side is ready: a beat is
// registered, then processed by the motor lanes once the result slot is free,
// which updates the state registers and so the result.
// Results come straight from the state registers, so a stalled result holds.
// Reset (synchronous, active low) clears all control state; no clearing pass.
module trapezoid_step_pulse_generator #(
    parameter int MOTOR_COUNT = tspg_pkg::DEF_MOTOR_COUNT,
    parameter int FRAC_BITS   = tspg_pkg::DEF_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [tspg_pkg::CMD_W-1:0]            i_command,
    input  logic [tspg_pkg::IDX_W-1:0]            i_motor_index,
    input  logic                                  i_direction,
    input  logic [tspg_pkg::TICK_W-1:0]           i_steps_to_move,
    input  logic signed [tspg_pkg::RATE_W-1:0]    i_initial_rate,
    input  logic signed [tspg_pkg::RATE_W-1:0]    i_accel_change,
    input  logic signed [tspg_pkg::RATE_W-1:0]    i_decel_change,
    input  logic signed [tspg_pkg::RATE_W-1:0]    i_plateau_rate,
    input  logic [tspg_pkg::TICK_W-1:0]           i_first_accel_event,
    input  logic [tspg_pkg::TICK_W-1:0]           i_block_time,
    input  logic [tspg_pkg::MASK_W-1:0]           i_stop_mask,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [tspg_pkg::MASK_W-1:0]           o_step_mask,
    output logic [tspg_pkg::MASK_W-1:0]           o_direction_mask,
    output logic [tspg_pkg::MASK_W-1:0]           o_moving_mask,
    output logic                                  o_running,
    output logic                                  o_block_done,
    output logic [tspg_pkg::MISS_W-1:0]           o_missed_unsteps
);
    import tspg_pkg::*;
    `include "assert_macros.svh"

    // ---------------- input beat register ----------------
    logic                 r_in_valid;
    logic [CMD_W-1:0]     r_command;
    logic [IDX_W-1:0]     r_motor_index;
    logic                 r_direction;
    t_lane_load           r_load;
    logic [TICK_W-1:0]    r_block_time;
    logic [MASK_W-1:0]    r_stop_mask;

    // ---------------- block state ----------------
    logic                   r_out_valid, r_block_done;
    logic [MOTOR_COUNT-1:0] r_moving, r_dir, r_pins;
    logic [TICK_W-1:0]      r_accel_end, r_decel_start, r_block_length, r_tick_count;
    logic                   r_busy;
    logic [MISS_W-1:0]      r_missed;

    logic [MOTOR_COUNT-1:0] n_moving, n_dir, n_pins;
    logic [TICK_W-1:0]      n_accel_end, n_decel_start, n_block_length, n_tick_count;
    logic                   n_busy, n_block_done;
    logic [MISS_W-1:0]      n_missed;

    logic                   adv;        // the registered beat is processed this cycle
    logic                   clear_all;  // drop every motor's target
    logic                   lane_tick;
    t_lane_ctrl             lane_ctrl;
    t_lane_stat             lane_stat [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] load_en, stop_ext, moving_after_stop;
    logic [MOTOR_COUNT-1:0] active_vec, step_vec, finish_vec;

    // Processing needs a free result slot; a new beat enters when the slot
    // ahead of it empties, so the input side keeps streaming.
    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_command             <= i_command;
            r_motor_index         <= i_motor_index;
            r_direction           <= i_direction;
            r_load.steps          <= i_steps_to_move;
            r_load.init_rate      <= i_initial_rate;
            r_load.accel          <= i_accel_change;
            r_load.decel          <= i_decel_change;
            r_load.plateau        <= i_plateau_rate;
            r_load.first_event    <= i_first_accel_event;
            r_block_time          <= i_block_time;
            r_stop_mask           <= i_stop_mask;
        end
    end

    // ---------------- motor lanes ----------------
    assign lane_tick = adv && (t_cmd'(r_command) == CMD_TICK) && r_busy;

    assign lane_ctrl.tick         = lane_tick;
    assign lane_ctrl.tick_count   = r_tick_count;
    assign lane_ctrl.accel_end    = r_accel_end;
    assign lane_ctrl.decel_start  = r_decel_start;
    assign lane_ctrl.block_length = r_block_length;

    assign moving_after_stop = r_moving & ~stop_ext;

    for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
        // stop inputs exist for the first MASK_W motors only
        if (m < MASK_W) begin : g_stop
            assign stop_ext[m] = r_stop_mask[m];
        end else begin : g_nostop
            assign stop_ext[m] = 1'b0;
        end

        assign load_en[m] = adv && (t_cmd'(r_command) == CMD_LOAD) && !r_busy
                            && (int'(r_motor_index) == m);

        tspg_motor #(
            .FRAC_BITS (FRAC_BITS)
        ) u_motor (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load_en (load_en[m]),
            .i_load    (r_load),
            .i_ctrl    (lane_ctrl),
            .i_moving  (moving_after_stop[m]),
            .i_clear   (clear_all),
            .o_stat    (lane_stat[m])
        );

        assign active_vec[m] = lane_stat[m].active;
        assign step_vec[m]   = lane_stat[m].step;
        assign finish_vec[m] = lane_stat[m].finish;
    end

    // ---------------- command processing ----------------
    always_comb begin
        n_moving       = r_moving;
        n_dir          = r_dir;
        n_pins         = r_pins;
        n_accel_end    = r_accel_end;
        n_decel_start  = r_decel_start;
        n_block_length = r_block_length;
        n_tick_count   = r_tick_count;
        n_busy         = r_busy;
        n_missed       = r_missed;
        n_block_done   = 1'b0;
        clear_all      = 1'b0;
        if (adv) begin
            case (t_cmd'(r_command))
                CMD_LOAD: begin
                    n_dir = r_dir | load_en;
                    if (!r_direction) begin
                        n_dir = r_dir & ~load_en;
                    end
                end
                CMD_ACCEL_END: begin
                    if (!r_busy) begin
                        n_accel_end = r_block_time;
                    end
                end
                CMD_DECEL_BEG: begin
                    if (!r_busy) begin
                        n_decel_start = r_block_time;
                    end
                end
                CMD_START: begin
                    if (!r_busy) begin
                        n_block_length = r_block_time;
                        n_tick_count   = '0;
                        n_moving       = active_vec;
                        // an empty block is done at once
                        n_busy         = (active_vec != '0);
                        n_block_done   = (active_vec == '0);
                    end
                end
                CMD_TICK: begin
                    // pins still high from the last tick count as a missed unstep
                    if (r_pins != '0) begin
                        n_pins = '0;
                        if (r_missed != '1) begin
                            n_missed = r_missed + MISS_W'(1);
                        end
                    end
                    if (r_busy) begin
                        n_pins       = n_pins | step_vec;
                        n_moving     = moving_after_stop & ~finish_vec;
                        n_tick_count = r_tick_count + TICK_W'(1);
                        if (n_moving == '0) begin
                            n_tick_count = '0;
                            n_busy       = 1'b0;
                            clear_all    = 1'b1;
                            n_block_done = 1'b1;
                        end
                    end
                end
                CMD_HALT: begin
                    if (r_busy) begin
                        n_busy       = 1'b0;
                        n_tick_count = '0;
                        n_moving     = '0;
                        clear_all    = 1'b1;
                    end
                end
                CMD_UNSTEP: begin
                    n_pins = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_block_done   <= 1'b0;
            r_moving       <= '0;
            r_dir          <= '0;
            r_pins         <= '0;
            r_accel_end    <= '0;
            r_decel_start  <= '0;
            r_block_length <= '0;
            r_tick_count   <= '0;
            r_busy         <= 1'b0;
            r_missed       <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                r_block_done   <= n_block_done;
                r_moving       <= n_moving;
                r_dir          <= n_dir;
                r_pins         <= n_pins;
                r_accel_end    <= n_accel_end;
                r_decel_start  <= n_decel_start;
                r_block_length <= n_block_length;
                r_tick_count   <= n_tick_count;
                r_busy         <= n_busy;
                r_missed       <= n_missed;
            end
        end
    end

    // ---------------- result beat ----------------
    // State only moves when a result is loaded, so it doubles as the result register.
    assign o_valid          = r_out_valid;
    assign o_running        = r_busy;
    assign o_block_done     = r_block_done;
    assign o_missed_unsteps = r_missed;

    for (genvar b = 0; b < MASK_W; b++) begin : g_out
        if (b < MOTOR_COUNT) begin : g_motor
            assign o_step_mask[b]      = r_pins[b];
            assign o_direction_mask[b] = r_dir[b];
            assign o_moving_mask[b]    = r_moving[b];
        end else begin : g_none
            assign o_step_mask[b]      = 1'b0;
            assign o_direction_mask[b] = 1'b0;
            assign o_moving_mask[b]    = 1'b0;
        end
    end

    `AST_IMPLY(a_busy_iff_moving, i_clk, i_rst_n, 1'b1, r_busy == (r_moving != '0),
        "busy and moving set disagree")
    `AST_IMPLY(a_done_not_running, i_clk, i_rst_n, r_out_valid && r_block_done, !r_busy,
        "block done while still running")
    `AST_NEXT(a_missed_monotonic, i_clk, i_rst_n, 1'b1, r_missed >= $past(r_missed),
        "missed unstep count decreased")
    `AST_NEXT(a_stall_holds_state, i_clk, i_rst_n, r_out_valid && !i_ready,
        r_tick_count == $past(r_tick_count) && r_pins == $past(r_pins),
        "state moved while result stalled")

endmodule

/* tb/trapezoid_step_pulse_generator_tb.sv */
// Testbench for the trapezoid step pulse generator: directed and random beats,
// checked against a cycle-free predictor of the block state. Uses tspg_pkg.
`timescale 1ns / 100ps

module trapezoid_step_pulse_generator_tb;
    import tspg_pkg::*;

    localparam int MOTOR_COUNT    = DEF_MOTOR_COUNT;
    localparam int FRAC_BITS      = DEF_FRAC_BITS;
    localparam int ONE_STEP       = 1 << FRAC_BITS;
    localparam int RANDOM_BEATS   = 1700;
    localparam int DRAIN_CYCLES   = 8;      // margin after the last result
    localparam int WATCHDOG_LIMIT = 3000;   // idle cycles, well above any stall
    localparam int MAX_REPORTS    = 10;
    localparam int STALL_CYCLES   = 120;

    // Command 7 has no meaning; the block must leave its state alone.
    localparam logic [CMD_W-1:0] CMD_UNDEF = 3'd7;

    // One input beat, field for field as the ports carry it.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  motor_index;
        logic              direction;
        logic [TICK_W-1:0] steps;
        logic [RATE_W-1:0] init_rate;
        logic [RATE_W-1:0] accel;
        logic [RATE_W-1:0] decel;
        logic [RATE_W-1:0] plateau;
        logic [TICK_W-1:0] first_event;
        logic [TICK_W-1:0] block_time;
        logic [MASK_W-1:0] stop_mask;
    } cmd_beat_t;

    // One result beat.
    typedef struct packed {
        logic [MASK_W-1:0] step_mask;
        logic [MASK_W-1:0] dir_mask;
        logic [MASK_W-1:0] moving_mask;
        logic              running;
        logic              done;
        logic [MISS_W-1:0] missed;
    } gen_status_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [CMD_W-1:0]         i_command;
    logic [IDX_W-1:0]         i_motor_index;
    logic                     i_direction;
    logic [TICK_W-1:0]        i_steps_to_move;
    logic signed [RATE_W-1:0] i_initial_rate;
    logic signed [RATE_W-1:0] i_accel_change;
    logic signed [RATE_W-1:0] i_decel_change;
    logic signed [RATE_W-1:0] i_plateau_rate;
    logic [TICK_W-1:0]        i_first_accel_event;
    logic [TICK_W-1:0]        i_block_time;
    logic [MASK_W-1:0]        i_stop_mask;
    logic                     o_valid;
    logic                     i_ready;
    logic [MASK_W-1:0]        o_step_mask;
    logic [MASK_W-1:0]        o_direction_mask;
    logic [MASK_W-1:0]        o_moving_mask;
    logic                     o_running;
    logic                     o_block_done;
    logic [MISS_W-1:0]        o_missed_unsteps;

    trapezoid_step_pulse_generator #(
        .MOTOR_COUNT (MOTOR_COUNT),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_command           (i_command),
        .i_motor_index       (i_motor_index),
        .i_direction         (i_direction),
        .i_steps_to_move     (i_steps_to_move),
        .i_initial_rate      (i_initial_rate),
        .i_accel_change      (i_accel_change),
        .i_decel_change      (i_decel_change),
        .i_plateau_rate      (i_plateau_rate),
        .i_first_accel_event (i_first_accel_event),
        .i_block_time        (i_block_time),
        .i_stop_mask         (i_stop_mask),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_step_mask         (o_step_mask),
        .o_direction_mask    (o_direction_mask),
        .o_moving_mask       (o_moving_mask),
        .o_running           (o_running),
        .o_block_done        (o_block_done),
        .o_missed_unsteps    (o_missed_unsteps)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted block state. Bit types so everything starts at zero,
    // which is also the state right after reset.
    // ------------------------------------------------------------------
    bit [TICK_W-1:0] lane_target  [MOTOR_COUNT];
    bit [TICK_W-1:0] lane_steps   [MOTOR_COUNT];
    bit [RATE_W-1:0] lane_rate    [MOTOR_COUNT];
    bit [RATE_W-1:0] lane_rchg    [MOTOR_COUNT];
    bit [RATE_W-1:0] lane_dchg    [MOTOR_COUNT];
    bit [RATE_W-1:0] lane_plateau [MOTOR_COUNT];
    bit [TICK_W-1:0] lane_next_ev [MOTOR_COUNT];
    bit [RATE_W-1:0] lane_accum   [MOTOR_COUNT];
    bit [MASK_W-1:0] moving_bits;
    bit [MASK_W-1:0] dir_bits;
    bit [TICK_W-1:0] accel_end_mark;
    bit [TICK_W-1:0] decel_start_mark;
    bit [TICK_W-1:0] block_len;
    bit [TICK_W-1:0] tick_ctr;
    bit              gen_busy;
    bit [MASK_W-1:0] pin_bits;
    bit [MISS_W-1:0] missed_ctr;

    gen_status_t expected_status_q [$];
    int          err_count;
    int          beats_sent;
    int          stuck_cycles;
    int          rx_hold_req;   // one-shot long hold-off for the result side
    bit          tx_no_idle;
    bit          rx_no_idle;

    // Applies one accepted beat to the predicted state and returns the
    // status the block must report for it.
    function automatic gen_status_t step_gen_predict(input cmd_beat_t b);
        gen_status_t     r;
        bit [MASK_W-1:0] act;
        bit              still;
        bit              done;
        int              m;
        done = 1'b0;
        case (b.cmd)
            CMD_LOAD: begin
                // setup is locked while running; indexes 6 and 7 are dropped
                if (!gen_busy && b.motor_index < MOTOR_COUNT) begin
                    lane_target[b.motor_index]  = b.steps;
                    lane_rate[b.motor_index]    = b.init_rate;
                    lane_rchg[b.motor_index]    = b.accel;
                    lane_dchg[b.motor_index]    = b.decel;
                    lane_plateau[b.motor_index] = b.plateau;
                    lane_next_ev[b.motor_index] = b.first_event;
                    lane_steps[b.motor_index]   = '0;
                    lane_accum[b.motor_index]   = '0;
                    dir_bits[b.motor_index]     = b.direction;
                end
            end
            CMD_ACCEL_END: begin
                if (!gen_busy) accel_end_mark = b.block_time;
            end
            CMD_DECEL_BEG: begin
                if (!gen_busy) decel_start_mark = b.block_time;
            end
            CMD_START: begin
                if (!gen_busy) begin
                    act = '0;
                    for (m = 0; m < MOTOR_COUNT; m++)
                        act[m] = (lane_target[m] != 0);
                    block_len   = b.block_time;
                    tick_ctr    = '0;
                    moving_bits = act;
                    // a block with no active motor finishes on the spot
                    if (act != 0) gen_busy = 1'b1;
                    else done = 1'b1;
                end
            end
            CMD_TICK: begin
                // pins left high since the last tick count as missed unsteps
                if (pin_bits != 0) begin
                    pin_bits = '0;
                    if (missed_ctr != '1) missed_ctr++;
                end
                if (gen_busy) begin
                    still = 1'b0;
                    moving_bits &= ~b.stop_mask;
                    for (m = 0; m < MOTOR_COUNT; m++) begin
                        if (lane_target[m] != 0) begin
                            lane_rate[m] += lane_rchg[m];
                            if (tick_ctr == lane_next_ev[m]) begin
                                if (tick_ctr == accel_end_mark) begin
                                    lane_rchg[m] = '0;
                                    if (decel_start_mark < block_len) begin
                                        lane_next_ev[m] = decel_start_mark;
                                        if (tick_ctr != decel_start_mark)
                                            lane_rate[m] = lane_plateau[m];
                                    end
                                end
                                if (tick_ctr == decel_start_mark)
                                    lane_rchg[m] = lane_dchg[m];
                            end
                            // zero or negative rate: force a step now
                            if (lane_rate[m] == 0 || lane_rate[m][RATE_W-1]) begin
                                lane_accum[m] = ONE_STEP;
                                lane_rate[m]  = '0;
                            end
                            lane_accum[m] += lane_rate[m];
                            if (lane_accum[m] >= ONE_STEP) begin
                                lane_accum[m] -= ONE_STEP;
                                lane_steps[m]++;
                                pin_bits[m] = 1'b1;
                                // stopped motors finish on their next step
                                if (!moving_bits[m] || lane_steps[m] == lane_target[m]) begin
                                    lane_target[m] = '0;
                                    moving_bits[m] = 1'b0;
                                end
                            end
                            if (moving_bits[m]) still = 1'b1;
                        end
                    end
                    tick_ctr++;
                    if (!still) begin
                        tick_ctr = '0;
                        gen_busy = 1'b0;
                        for (m = 0; m < MOTOR_COUNT; m++) lane_target[m] = '0;
                        done = 1'b1;
                    end
                end
            end
            CMD_HALT: begin
                // abort without a done flag; idle halt is a no-op
                if (gen_busy) begin
                    gen_busy    = 1'b0;
                    tick_ctr    = '0;
                    moving_bits = '0;
                    for (m = 0; m < MOTOR_COUNT; m++) lane_target[m] = '0;
                end
            end
            CMD_UNSTEP: pin_bits = '0;
            default: ;
        endcase
        r = '{pin_bits, dir_bits, moving_bits, gen_busy, done, missed_ctr};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------
    function automatic cmd_beat_t quiet_beat(input logic [CMD_W-1:0] cmd);
        cmd_beat_t b;
        b = '0;
        b.cmd = cmd;
        return b;
    endfunction

    function automatic cmd_beat_t rand_beat();
        cmd_beat_t b;
        b.cmd         = CMD_W'($urandom_range(0, 7));
        b.motor_index = IDX_W'($urandom_range(0, 7));
        b.direction   = 1'($urandom_range(0, 1));
        b.steps       = TICK_W'($urandom);
        b.init_rate   = $urandom;
        b.accel       = $urandom;
        b.decel       = $urandom;
        b.plateau     = $urandom;
        b.first_event = TICK_W'($urandom);
        b.block_time  = TICK_W'($urandom);
        b.stop_mask   = MASK_W'($urandom);
        return b;
    endfunction

    function automatic cmd_beat_t load_beat(input logic [IDX_W-1:0] idx, input logic dir,
                                            input logic [TICK_W-1:0] steps,
                                            input logic [RATE_W-1:0] init_rate,
                                            input logic [RATE_W-1:0] accel,
                                            input logic [RATE_W-1:0] decel,
                                            input logic [RATE_W-1:0] plateau,
                                            input logic [TICK_W-1:0] first_event);
        cmd_beat_t b;
        b             = rand_beat();
        b.cmd         = CMD_LOAD;
        b.motor_index = idx;
        b.direction   = dir;
        b.steps       = steps;
        b.init_rate   = init_rate;
        b.accel       = accel;
        b.decel       = decel;
        b.plateau     = plateau;
        b.first_event = first_event;
        return b;
    endfunction

    // Profiles that finish in a few dozen ticks, with an occasional wild value
    // so every bit of every field toggles.
    function automatic cmd_beat_t rand_load_beat();
        logic [IDX_W-1:0]  idx;
        logic [TICK_W-1:0] steps;
        logic [RATE_W-1:0] init_rate, accel, decel, plateau;
        logic [TICK_W-1:0] first_event;
        idx = IDX_W'(($urandom_range(0, 11) == 0) ? $urandom_range(6, 7)
                                                  : $urandom_range(0, MOTOR_COUNT - 1));
        case ($urandom_range(0, 15))
            0, 1:    steps = '0;
            2:       steps = TICK_W'($urandom);
            default: steps = TICK_W'($urandom_range(1, 24));
        endcase
        init_rate   = ($urandom_range(0, 7) == 0) ? $urandom
                      : $urandom_range(ONE_STEP / 16, ONE_STEP);
        accel       = ($urandom_range(0, 7) == 0) ? $urandom
                      : $urandom_range(0, ONE_STEP / 32) - ONE_STEP / 96;
        decel       = ($urandom_range(0, 7) == 0) ? $urandom
                      : $urandom_range(0, ONE_STEP / 32) - ONE_STEP / 48;
        plateau     = ($urandom_range(0, 7) == 0) ? $urandom
                      : $urandom_range(ONE_STEP / 8, ONE_STEP);
        first_event = TICK_W'(($urandom_range(0, 15) == 0) ? $urandom
                                                           : $urandom_range(0, 40));
        return load_beat(idx, 1'($urandom_range(0, 1)), steps, init_rate, accel, decel,
                         plateau, first_event);
    endfunction

    function automatic logic [TICK_W-1:0] rand_mark();
        return TICK_W'(($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 40));
    endfunction

    // ------------------------------------------------------------------
    // Input side: optional gap, then hold the beat until it is taken.
    // The prediction is made at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_beat(input cmd_beat_t b);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_command           <= b.cmd;
        i_motor_index       <= b.motor_index;
        i_direction         <= b.direction;
        i_steps_to_move     <= b.steps;
        i_initial_rate      <= b.init_rate;
        i_accel_change      <= b.accel;
        i_decel_change      <= b.decel;
        i_plateau_rate      <= b.plateau;
        i_first_accel_event <= b.first_event;
        i_block_time        <= b.block_time;
        i_stop_mask         <= b.stop_mask;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_status_q.push_back(step_gen_predict(b));
        beats_sent++;
    endtask

    // Stop offering beats until every result is back, then let the
    // pipeline run empty.
    task automatic settle_outputs();
        i_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One block: loads, tick marks, start, then ticks with noise until the
    // block ends or a cap is hit. Now and then the start is left out.
    task automatic run_random_block();
        cmd_beat_t b;
        int        loads;
        int        ticks;
        int        tick_cap;
        int        pick;
        bit        broken;
        broken = ($urandom_range(0, 9) == 0);
        loads  = $urandom_range(1, 6);
        repeat (loads)
            send_beat(($urandom_range(0, 7) == 0) ? rand_beat() : rand_load_beat());
        b = rand_beat();
        b.cmd = CMD_ACCEL_END;
        b.block_time = rand_mark();
        send_beat(b);
        b = rand_beat();
        b.cmd = CMD_DECEL_BEG;
        b.block_time = rand_mark();
        send_beat(b);
        if (!broken) begin
            b = rand_beat();
            b.cmd = CMD_START;
            b.block_time = rand_mark();
            send_beat(b);
        end
        tick_cap = broken ? 4 : $urandom_range(10, 120);
        ticks = 0;
        while ((gen_busy || broken) && ticks < tick_cap) begin
            b = rand_beat();
            pick = $urandom_range(0, 39);
            if (pick < 28) begin
                b.cmd = CMD_TICK;
                if ($urandom_range(0, 15) != 0) b.stop_mask = '0;
            end else if (pick < 36) begin
                b.cmd = CMD_UNSTEP;
            end else if (pick == 39) begin
                b.cmd = CMD_HALT;
            end
            send_beat(b);
            ticks++;
        end
        if (gen_busy) send_beat(quiet_beat(CMD_HALT));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        cmd_beat_t b;
        // idle tick with every stop bit, unstep, idle halt, undefined command
        b = quiet_beat(CMD_TICK);
        b.stop_mask = '1;
        send_beat(b);
        send_beat(quiet_beat(CMD_UNSTEP));
        send_beat(quiet_beat(CMD_HALT));
        send_beat(quiet_beat(CMD_UNDEF));
        // nothing loaded: start reports done at once and stays idle
        send_beat(quiet_beat(CMD_START));
        // out-of-range motor indexes are dropped
        send_beat(load_beat(7, 1, 5, ONE_STEP, 0, 0, 0, 0));
        send_beat(load_beat(6, 1, 5, ONE_STEP, 0, 0, 0, 0));
        // most negative rate forces a step every tick
        send_beat(load_beat(0, 1, 3, 32'h8000_0000, '0, 32'h7FFF_FFFF, '0, '0));
        // widest fields, accumulator and rate wrap
        send_beat(load_beat(5, 1, '1, 32'h7FFF_FFFF, 32'h8000_0000, '1,
                            32'h7FFF_FFFF, '1));
        // regular ramp through the accel end mark to the plateau, done before decel
        send_beat(load_beat(2, 0, 2, ONE_STEP / 2, ONE_STEP / 4, -(ONE_STEP / 4),
                            ONE_STEP, 1));
        b = quiet_beat(CMD_ACCEL_END);
        b.block_time = 1;
        send_beat(b);
        b = quiet_beat(CMD_DECEL_BEG);
        b.block_time = 3;
        send_beat(b);
        b = quiet_beat(CMD_START);
        b.block_time = 5;
        send_beat(b);
        // setup beats while running must be ignored
        send_beat(load_beat(1, 1, 4, ONE_STEP, 0, 0, 0, 0));
        b = quiet_beat(CMD_ACCEL_END);
        b.block_time = '1;
        send_beat(b);
        b = quiet_beat(CMD_START);
        b.block_time = '1;
        send_beat(b);
        send_beat(quiet_beat(CMD_TICK));
        send_beat(quiet_beat(CMD_TICK));
        send_beat(quiet_beat(CMD_UNSTEP));
        send_beat(quiet_beat(CMD_TICK));
        // external stop of the endless motor
        b = quiet_beat(CMD_TICK);
        b.stop_mask = 6'h20;
        send_beat(b);
        send_beat(quiet_beat(CMD_TICK));
        // halt while a block runs
        send_beat(load_beat(3, 0, '1, 1, 0, 0, 0, 0));
        send_beat(quiet_beat(CMD_START));
        send_beat(quiet_beat(CMD_TICK));
        send_beat(quiet_beat(CMD_HALT));
        settle_outputs();
    endtask

    // Result side holds off for a long stretch while ticks keep coming
    // back to back, so the block fills and stalls its input.
    task automatic test_output_stall();
        cmd_beat_t b;
        b = rand_load_beat();
        b.motor_index = 0;
        b.steps = '1;
        send_beat(b);
        b = rand_beat();
        b.cmd = CMD_START;
        b.block_time = '1;
        send_beat(b);
        tx_no_idle  = 1'b1;
        rx_hold_req = STALL_CYCLES;
        repeat (60) begin
            b = rand_beat();
            b.cmd = CMD_TICK;
            b.stop_mask = '0;
            send_beat(b);
        end
        send_beat(quiet_beat(CMD_HALT));
        tx_no_idle = 1'b0;
        settle_outputs();
    endtask

    // Both sides at full rate.
    task automatic test_streaming();
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        repeat (3) run_random_block();
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        settle_outputs();
    endtask

    task automatic test_random_blocks();
        int stop_at;
        stop_at = beats_sent + RANDOM_BEATS;
        while (beats_sent < stop_at) run_random_block();
        settle_outputs();
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready gaps, plus the one-shot long hold.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int wait_cycles;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            wait_cycles = rx_no_idle ? 0 : $urandom_range(0, 7);
            if (rx_hold_req != 0) begin
                wait_cycles += rx_hold_req;
                rx_hold_req = 0;
            end
            if (wait_cycles != 0) begin
                i_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin : status_check
        gen_status_t got;
        gen_status_t want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_step_mask, o_direction_mask, o_moving_mask, o_running,
                    o_block_done, o_missed_unsteps};
            if (expected_status_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing predicted: %p", $realtime, got);
            end else begin
                want = expected_status_q.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: status mismatch", $realtime);
                        $display("  exp step=%h dir=%h mov=%h run=%b done=%b miss=%0d",
                                 want.step_mask, want.dir_mask, want.moving_mask,
                                 want.running, want.done, want.missed);
                        $display("  got step=%h dir=%h mov=%h run=%b done=%b miss=%0d",
                                 got.step_mask, got.dir_mask, got.moving_mask,
                                 got.running, got.done, got.missed);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any beat moving on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_valid             <= 1'b0;
        i_command           <= '0;
        i_motor_index       <= '0;
        i_direction         <= 1'b0;
        i_steps_to_move     <= '0;
        i_initial_rate      <= '0;
        i_accel_change      <= '0;
        i_decel_change      <= '0;
        i_plateau_rate      <= '0;
        i_first_accel_event <= '0;
        i_block_time        <= '0;
        i_stop_mask         <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_output_stall();
        test_streaming();
        test_random_blocks();

        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
